// ----- design/iir_df2_pkg.sv -----
// Shared types, constants and the round/saturate function of the direct form II IIR filter.
// No dependencies; used by the controller, the datapath and the top level.
package iir_df2_pkg;

    localparam int ORDER     = 2;
    localparam int NUM_TAPS  = 2;
    localparam int EFF_ORDER = (ORDER > NUM_TAPS) ? NUM_TAPS : ORDER;
    localparam int NUM_COEF  = NUM_TAPS + 1;
    localparam int TAP_CNT_W = $clog2(EFF_ORDER + 1);
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int TAP_IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_SH = 14;
    localparam int RND_W   = ACC_W - FRAC_SH;
    localparam int ROUND_BIAS = 1 << (FRAC_SH - 1);

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_2 = 3'd5;

    localparam logic signed [DATA_W-1:0] COEF_UNITY = 16'sd16384;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef sample_t [NUM_COEF-1:0] coef_vec_t;

    typedef struct packed {
        logic                 load_x;
        logic                 mul_en;
        logic                 phase_y;
        logic [TAP_CNT_W-1:0] tap;
        logic                 acc_load;
        logic                 acc_add;
        logic                 round_w;
        logic                 round_y;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        sample_t value;
        logic    sat;
    } rnd_t;

    // Round a Q3.29 sum to Q1.15 (ties toward plus infinity) and saturate.
    function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [RND_W-1:0] r;
        logic signed [RND_W-1:0] sat_max;
        logic signed [RND_W-1:0] sat_min;
        rnd_t res;
        sat_max = RND_W'(32767);
        sat_min = RND_W'(-32768);
        biased  = acc + ACC_W'(ROUND_BIAS);
        r       = biased[ACC_W-1:FRAC_SH];
        if (r > sat_max) begin
            res.value = sat_max[DATA_W-1:0];
            res.sat   = 1'b1;
        end else if (r < sat_min) begin
            res.value = sat_min[DATA_W-1:0];
            res.sat   = 1'b1;
        end else begin
            res.value = r[DATA_W-1:0];
            res.sat   = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- design/iir_df2_ctrl.sv -----
// Sequencer of the direct form II IIR filter: steps the shared multiplier over the taps.
// Depends on iir_df2_pkg for the command and status types.
module iir_df2_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  iir_df2_pkg::dp_status_t status,
    output iir_df2_pkg::dp_cmd_t    cmd
);
    import iir_df2_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_ROUND
    } state_t;

    state_t               state_reg;
    logic                 phase_reg;
    logic [TAP_CNT_W-1:0] tap_reg;

    localparam logic [TAP_CNT_W-1:0] LAST_TAP = TAP_CNT_W'(EFF_ORDER);
    localparam logic [TAP_CNT_W-1:0] FIRST_ADD_TAP = TAP_CNT_W'(1);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.phase_y  = phase_reg;
        cmd.tap      = tap_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_x = s_valid;
            end
            ST_MUL: begin
                cmd.mul_en   = 1'b1;
                // product of the previous tap is ready now
                cmd.acc_load = (tap_reg == FIRST_ADD_TAP);
                cmd.acc_add  = (tap_reg > FIRST_ADD_TAP);
            end
            ST_DRAIN: begin
                cmd.acc_add = 1'b1;
            end
            ST_ROUND: begin
                cmd.round_w = !phase_reg;
                cmd.round_y = phase_reg && !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            tap_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_MUL;
                        phase_reg <= 1'b0;
                        tap_reg   <= '0;
                    end
                end
                ST_MUL: begin
                    if (tap_reg == LAST_TAP) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (!phase_reg) begin
                        state_reg <= ST_MUL;
                        phase_reg <= 1'b1;
                        tap_reg   <= '0;
                    end else if (!status.out_busy) begin
                        // hold until the output register is free
                        state_reg <= ST_IDLE;
                        phase_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/iir_df2_dp.sv -----
// Datapath of the direct form II IIR filter: shared multiplier, accumulator, delay line
// and output register. Depends on iir_df2_pkg; driven by iir_df2_ctrl.
module iir_df2_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  iir_df2_pkg::dp_cmd_t    cmd,
    output iir_df2_pkg::dp_status_t status,
    input  iir_df2_pkg::coef_vec_t  ff_coef,
    input  iir_df2_pkg::coef_vec_t  fb_coef,
    input  iir_df2_pkg::sample_t    s_sample_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output iir_df2_pkg::sample_t    m_sample_out,
    output logic                    m_clipped
);
    import iir_df2_pkg::*;

    sample_t                  x_reg;
    sample_t                  w_reg;
    sample_t                  dly_reg [NUM_TAPS];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     clip_reg;
    logic                     out_valid_reg;
    sample_t                  out_sample_reg;
    logic                     out_clip_reg;

    sample_t                  coef_sel;
    sample_t                  data_sel;
    rnd_t                     rnd;
    logic [TAP_IDX_W-1:0]     tap_idx;

    assign tap_idx = TAP_IDX_W'(cmd.tap - 1'b1);

    always_comb begin
        coef_sel = cmd.phase_y ? ff_coef[COEF_IDX_W'(cmd.tap)] : fb_coef[COEF_IDX_W'(cmd.tap)];
        if (cmd.tap == '0) begin
            data_sel = cmd.phase_y ? w_reg : x_reg;
        end else begin
            data_sel = dly_reg[tap_idx];
        end
    end

    assign rnd = round_sat(acc_reg);

    assign status.out_busy = out_valid_reg && !m_ready;
    assign m_valid         = out_valid_reg;
    assign m_sample_out    = out_sample_reg;
    assign m_clipped       = out_clip_reg;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg <= s_sample_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= coef_sel * data_sel;
        end
        if (cmd.acc_load) begin
            acc_reg <= ACC_W'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.round_w) begin
            w_reg    <= rnd.value;
            clip_reg <= rnd.sat;
        end
        if (cmd.round_y) begin
            out_sample_reg <= rnd.value;
            out_clip_reg   <= clip_reg | rnd.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                dly_reg[i] <= '0;
            end
        end else begin
            if (cmd.round_y) begin
                out_valid_reg <= 1'b1;
                // advance the delay line and push the new intermediate value
                for (int i = NUM_TAPS - 1; i > 0; i--) begin
                    dly_reg[i] <= dly_reg[i-1];
                end
                dly_reg[0] <= w_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/iir_direct_form_two.sv -----
// Top level of the direct form II IIR filter: APB coefficient registers and the
// controller/datapath pair. Depends on iir_df2_pkg, iir_df2_ctrl and iir_df2_dp.
//
// Use: write coefficients over the APB port while the filter is idle. Registers
// ff_coef_0..2 lie at byte addresses 0, 4, 8 and fb_coef_0..2 at 12, 16, 20; each
// is a signed Q2.14 value in pwdata[15:0], read back sign-extended to 32 bits.
// Samples (signed Q1.15) enter on the s_ channel with valid/ready; each request
// yields one filtered sample and a clip flag on the m_ channel.
// One shared 16x16 multiplier runs over the taps twice per sample, once for the
// intermediate value and once for the output. A new sample is taken only when
// the sequencer is idle, after the previous sample has been fully worked on.
// The output register holds the last result while the next sample is worked on;
// a stalled receiver holds the sequencer before the final rounding step.
// Reset (aresetn low, synchronous) clears the delay line, restores the reset
// coefficients (unity gain, no feedback) and drops any pending result.
module iir_direct_form_two (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [iir_df2_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [iir_df2_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [iir_df2_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [iir_df2_pkg::DATA_W-1:0]  s_sample_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [iir_df2_pkg::DATA_W-1:0]  m_sample_out,
    output logic                                   m_clipped
);
    import iir_df2_pkg::*;

    // unity weight on the current value, zero on every delay
    localparam coef_vec_t COEF_RESET = {{(NUM_COEF-1){sample_t'(0)}}, COEF_UNITY};

    coef_vec_t            ff_coef_reg;
    coef_vec_t            fb_coef_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    sample_t              wr_val;
    sample_t              rd_val;
    dp_cmd_t              cmd;
    dp_status_t           status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_coef_reg <= COEF_RESET;
            fb_coef_reg <= COEF_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FF_COEF_0: ff_coef_reg[0] <= wr_val;
                REG_FF_COEF_1: ff_coef_reg[1] <= wr_val;
                REG_FF_COEF_2: ff_coef_reg[2] <= wr_val;
                REG_FB_COEF_0: fb_coef_reg[0] <= wr_val;
                REG_FB_COEF_1: fb_coef_reg[1] <= wr_val;
                REG_FB_COEF_2: fb_coef_reg[2] <= wr_val;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FF_COEF_0: rd_val = ff_coef_reg[0];
            REG_FF_COEF_1: rd_val = ff_coef_reg[1];
            REG_FF_COEF_2: rd_val = ff_coef_reg[2];
            REG_FB_COEF_0: rd_val = fb_coef_reg[0];
            REG_FB_COEF_1: rd_val = fb_coef_reg[1];
            REG_FB_COEF_2: rd_val = fb_coef_reg[2];
            default:       rd_val = '0;
        endcase
        prdata = APB_DATA_W'(rd_val);
    end

    iir_df2_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    iir_df2_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .ff_coef      (ff_coef_reg),
        .fb_coef      (fb_coef_reg),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped)
    );

endmodule

// ----- bench/iir_direct_form_two_tb.sv -----
// Self-checking bench for the direct form II IIR filter: random and directed samples,
// a bit-exact Q1.15 filter predictor and APB coefficient writes between phases.
// Depends on iir_df2_pkg and the iir_direct_form_two top level.
module iir_direct_form_two_tb;
    import iir_df2_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_0 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_1 = 3'd7;
    localparam int SETTLE_CYCLES   = 2 * EFF_ORDER + 8;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AT_A       = 300;
    localparam int HOLD_AT_B       = 1100;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        sample_t y;
        logic    clip;
    } filtered_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sample_t               s_sample_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sample_t               m_sample_out;
    logic                  m_clipped;

    // filter state mirrored from the block
    sample_t ff_model [NUM_COEF];
    sample_t fb_model [NUM_COEF];
    sample_t delay_model [NUM_TAPS];

    sample_t   samples_to_send [$];
    filtered_t filtered_due [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    iir_direct_form_two u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Round a Q3.29 sum to Q1.15, ties upward, then clamp to 16 bits.
    function automatic sample_t q15_round(input longint acc, inout logic sat);
        longint r;
        r = (acc + longint'(8192)) >>> FRAC_SH;
        if (r > 32767) begin
            sat = 1'b1;
            return sample_t'(16'h7FFF);
        end
        if (r < -32768) begin
            sat = 1'b1;
            return sample_t'(16'h8000);
        end
        return sample_t'(r);
    endfunction

    // Advance the filter by one sample and return the output it produces.
    function automatic filtered_t filter_step(input sample_t x);
        longint    acc;
        sample_t   w;
        logic      sat;
        filtered_t res;
        sat = 1'b0;
        acc = longint'(fb_model[0]) * longint'(x);
        for (int k = 1; k <= EFF_ORDER; k++)
            acc += longint'(fb_model[k]) * longint'(delay_model[k-1]);
        w = q15_round(acc, sat);
        acc = longint'(ff_model[0]) * longint'(w);
        for (int k = 1; k <= EFF_ORDER; k++)
            acc += longint'(ff_model[k]) * longint'(delay_model[k-1]);
        res.y = q15_round(acc, sat);
        res.clip = sat;
        for (int k = NUM_TAPS - 1; k > 0; k--)
            delay_model[k] = delay_model[k-1];
        delay_model[0] = w;
        return res;
    endfunction

    function automatic sample_t random_coef();
        case ($urandom_range(0, 3))
            0: return sample_t'($urandom);
            1: return sample_t'($urandom_range(0, 8192) - 4096);
            2: begin
                case ($urandom_range(0, 4))
                    0: return sample_t'(16'h7FFF);
                    1: return sample_t'(16'h8000);
                    2: return COEF_UNITY;
                    3: return -COEF_UNITY;
                    default: return '0;
                endcase
            end
            default: return sample_t'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input sample_t value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_FF_COEF_2)
            ff_model[idx] = value;
        else if (idx <= REG_FB_COEF_2)
            fb_model[idx - REG_FB_COEF_0] = value;
    endtask

    task automatic set_filter(input sample_t ff0, input sample_t ff1, input sample_t ff2,
                              input sample_t fb0, input sample_t fb1, input sample_t fb2);
        cfg_write(REG_FF_COEF_0, ff0);
        cfg_write(REG_FF_COEF_1, ff1);
        cfg_write(REG_FF_COEF_2, ff2);
        cfg_write(REG_FB_COEF_0, fb0);
        cfg_write(REG_FB_COEF_1, fb1);
        cfg_write(REG_FB_COEF_2, fb2);
    endtask

    // Hold until every request is taken and every output has come, then let the block settle.
    task automatic drain();
        do @(posedge aclk);
        while (samples_to_send.size() != 0 || s_valid || filtered_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : sample_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                filtered_due.push_back(filter_step(s_sample_in));
            if (!s_valid || s_ready) begin
                if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_sample_in <= samples_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : output_monitor
        filtered_t due;
        logic      took;
        took = 1'b0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                took = 1'b1;
                results_seen++;
                if (filtered_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected output: sample_out=%0d clipped=%0b",
                                 m_sample_out, m_clipped);
                    mismatch_count++;
                end else begin
                    due = filtered_due.pop_front();
                    if (m_sample_out !== due.y || m_clipped !== due.clip) begin
                        if (mismatch_count < 10)
                            $display("output %0d: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                                     results_seen, due.y, m_sample_out, due.clip, m_clipped);
                        mismatch_count++;
                    end
                end
            end
            // long hold-off so the block backs up onto its input
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (took && (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)) begin
                m_ready   <= 1'b0;
                hold_left <= HOLD_CYCLES;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (samples_to_send.size() == 0 && !s_valid && filtered_due.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        ff_model = '{COEF_UNITY, '0, '0};
        fb_model = '{COEF_UNITY, '0, '0};
        delay_model = '{default: '0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset coefficients: unity path, field extremes
        samples_to_send = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
                            16'sh5555, 16'shAAAA, 16'sh3039};
        drain();

        // ties in the rounding go upward
        set_filter(COEF_UNITY, '0, '0, sample_t'(1), '0, '0);
        samples_to_send = '{16'sh2000, 16'shE000, 16'sh6000, 16'shA000, 16'sh0001};
        drain();

        // extreme coefficients: the intermediate value saturates and feeds back clamped
        set_filter(sample_t'(16'h8000), sample_t'(16'h7FFF), sample_t'(16'h8000),
                   sample_t'(16'h7FFF), sample_t'(16'h8000), sample_t'(16'h7FFF));
        cfg_write(REG_SPARE_0, sample_t'($urandom));
        cfg_write(REG_SPARE_1, sample_t'($urandom));
        samples_to_send = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                            16'sh0001, 16'sh7FFF};
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin tx_idle_pct = 34; rx_idle_pct = 63; end
                1: begin tx_idle_pct = 63; rx_idle_pct = 34; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int set = 0; set < 3; set++) begin
                p = mode * 3 + set;
                if (p == 0)
                    // stable low-pass with feedback on both delays
                    set_filter(sample_t'(4096), sample_t'(8192), sample_t'(4096),
                               COEF_UNITY, sample_t'(13107), sample_t'(-6554));
                else if (p == 4)
                    set_filter(sample_t'(16'h7FFF), sample_t'(16'h7FFF), sample_t'(16'h7FFF),
                               sample_t'(16'h7FFF), sample_t'(16'h7FFF), sample_t'(16'h7FFF));
                else if (p == 8)
                    set_filter(sample_t'(16'h8000), sample_t'(16'h8000), sample_t'(16'h8000),
                               sample_t'(16'h8000), sample_t'(16'h8000), sample_t'(16'h8000));
                else
                    set_filter(random_coef(), random_coef(), random_coef(),
                               random_coef(), random_coef(), random_coef());
                if (p % 2 == 1) begin
                    cfg_write(REG_SPARE_0, sample_t'($urandom));
                    cfg_write(REG_SPARE_1, sample_t'($urandom));
                end
                repeat (ITEMS_PER_PHASE) begin
                    if ($urandom_range(0, 9) == 0) begin
                        case ($urandom_range(0, 2))
                            0: samples_to_send.push_back(sample_t'(16'h7FFF));
                            1: samples_to_send.push_back(sample_t'(16'h8000));
                            default: samples_to_send.push_back('0);
                        endcase
                    end else begin
                        samples_to_send.push_back(sample_t'($urandom));
                    end
                end
                drain();
            end
        end

        if (mismatch_count == 0 && filtered_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
